// ===== sv/bitmap_page_allocator_defines.svh =====
// ---------------------------------------------------------------------------
// Bitmap page allocator assertion macros
// Shared property wrappers for the allocator checks.
// ---------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// condition holds at every edge out of reset
`define BPA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BPA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Bitmap page allocator package
// Sizes, request kinds and shared types.
// ---------------------------------------------------------------------------
package bpa_pkg;

  localparam int MAX_PAGES = 65536;
  localparam int WORD_BITS = 32;
  localparam int MAP_WORDS = MAX_PAGES / WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int PAGE_W    = 16;
  localparam int CNT_W     = 17;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLAIM = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CNT_W-1:0]     count_t;
  typedef logic [KIND_W-1:0]    kind_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
    count_t           run_out;
  } find_t;

endpackage

// ===== sv/bpa_req_if.sv =====
// ---------------------------------------------------------------------------
// Allocator request channel
// Valid/ready channel carrying one allocate, free or claim request.
// ---------------------------------------------------------------------------
interface bpa_req_if;
  logic           valid;
  logic           ready;
  bpa_pkg::kind_t  kind;
  bpa_pkg::page_t  first_page;
  bpa_pkg::count_t page_count;

  modport source (output valid, kind, first_page, page_count, input ready);
  modport sink (input valid, kind, first_page, page_count, output ready);
endinterface

// ===== sv/bpa_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Allocator response channel
// Valid/ready channel carrying one result per request.
// ---------------------------------------------------------------------------
interface bpa_rsp_if;
  logic            valid;
  logic            ready;
  logic            status;
  bpa_pkg::page_t  start_page;
  bpa_pkg::count_t used_count;

  modport source (output valid, status, start_page, used_count, input ready);
  modport sink (input valid, status, start_page, used_count, output ready);
endinterface

// ===== sv/bpa_ram.sv =====
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module bpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bpa_word_find.sv =====
// ---------------------------------------------------------------------------
// Bitmap word run finder
// Finds the first window of free pages that ends in one bitmap word,
// given the run carried in from lower words, and the run carried out.
// ---------------------------------------------------------------------------
module bpa_word_find (
  input  bpa_pkg::word_t               avail,
  input  logic [bpa_pkg::BIT_W-1:0]    lo,
  input  bpa_pkg::count_t              run_in,
  input  bpa_pkg::count_t              need,
  output bpa_pkg::find_t               res
);

  localparam int WB = bpa_pkg::WORD_BITS;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int CW = bpa_pkg::CNT_W;

  bpa_pkg::word_t   r [0:BW];
  bpa_pkg::word_t   shifted;
  bpa_pkg::word_t   acc;
  logic [BW:0]      tz;
  logic [BW:0]      lead;
  logic [BW:0]      acc_len;
  logic [BW-1:0]    pos2;
  logic [CW:0]      head_sum;
  logic [CW:0]      pos1;
  logic             case1;
  logic             case2;
  logic             fits_word;

  always_comb begin
    shifted = avail >> lo;
    tz = (BW+1)'(WB);
    for (int i = WB - 1; i >= 0; i--) begin
      if (!shifted[i]) begin
        tz = (BW+1)'(i);
      end
    end
    lead = (BW+1)'(WB);
    for (int i = 0; i < WB; i++) begin
      if (!avail[i]) begin
        lead = (BW+1)'(WB - 1 - i);
      end
    end

    head_sum = {1'b0, run_in} + (CW+1)'(tz);
    case1    = head_sum >= {1'b0, need};
    pos1     = {1'b0, need} - {1'b0, run_in} - (CW+1)'(1) + (CW+1)'(lo);

    r[0] = avail;
    for (int k = 1; k <= BW; k++) begin
      r[k] = r[k-1] & (r[k-1] << (1 << (k - 1)));
    end
    acc     = '1;
    acc_len = '0;
    for (int k = 0; k <= BW; k++) begin
      if (need[k]) begin
        acc     = acc & (r[k] << acc_len);
        acc_len = acc_len + (BW+1)'(1 << k);
      end
    end
    fits_word = need <= CW'(WB);
    case2     = fits_word && (acc != '0);
    pos2  = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (acc[i]) begin
        pos2 = BW'(i);
      end
    end

    res.found = case1 || case2;
    res.pos   = case1 ? pos1[BW-1:0] : pos2;
    if (lead == (BW+1)'(WB) - (BW+1)'(lo)) begin
      res.run_out = run_in + CW'(lead);
    end else begin
      res.run_out = CW'(lead);
    end
  end

endmodule

// ===== sv/bitmap_page_allocator.sv =====
// ---------------------------------------------------------------------------
// Bitmap page allocator
// Next-fit physical page allocator over a free-page bitmap held in RAM.
// ---------------------------------------------------------------------------
// The bitmap (one bit per page, set = free) sits in a 2048 x 32 RAM and each
// walk reads it one word per cycle through the single read port, writing
// modified words back behind the read. After reset a clearing pass over all
// 2048 words runs before the first request is taken. A write of the page total
// starts a recount of the free pages below it. A free walks the words of its
// range once; a claim walks it to check, then again to take if all free;
// an allocate scans from the hint to the total, possibly again from page zero,
// then walks the chosen run once more to mark it used. One request is worked
// on at a time; a result waits in the output register while the next request
// is accepted.
module bitmap_page_allocator (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  bpa_pkg::count_t        cfg_wdata,
  bpa_req_if.sink                req,
  bpa_rsp_if.source              rsp
);

  `include "bitmap_page_allocator_defines.svh"

  localparam int AW = bpa_pkg::ADDR_W;
  localparam int BW = bpa_pkg::BIT_W;
  localparam int PW = bpa_pkg::PAGE_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int WB = bpa_pkg::WORD_BITS;

  localparam logic [2:0] ST_CLEAR   = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_RECOUNT = 3'd2;
  localparam logic [2:0] ST_FREE    = 3'd3;
  localparam logic [2:0] ST_CHECK   = 3'd4;
  localparam logic [2:0] ST_TAKE    = 3'd5;
  localparam logic [2:0] ST_SCAN    = 3'd6;
  localparam logic [2:0] ST_RESP    = 3'd7;

  function automatic logic [BW:0] popcnt(bpa_pkg::word_t w);
    logic [BW:0] c;
    c = '0;
    for (int i = 0; i < WB; i++) begin
      c = c + (BW+1)'(w[i]);
    end
    return c;
  endfunction

  logic [2:0]       state, state_next;
  bpa_pkg::count_t  total, total_next;
  bpa_pkg::count_t  free_count, free_count_next;
  bpa_pkg::page_t   hint, hint_next;
  bpa_pkg::kind_t   req_kind, req_kind_next;
  bpa_pkg::page_t   req_first, req_first_next;
  bpa_pkg::count_t  req_n, req_n_next;
  bpa_pkg::count_t  rng_lo, rng_lo_next;
  bpa_pkg::count_t  rng_hi, rng_hi_next;
  logic [AW-1:0]    rd_addr, rd_addr_next;
  logic [AW-1:0]    rd_last, rd_last_next;
  logic             rd_run, rd_run_next;
  logic             p_valid, p_valid_next;
  logic [AW-1:0]    p_addr, p_addr_next;
  bpa_pkg::count_t  acc, acc_next;
  bpa_pkg::count_t  run, run_next;
  logic             wrap_pend, wrap_pend_next;
  logic             res_status, res_status_next;
  bpa_pkg::page_t   res_start, res_start_next;
  logic             out_load;

  logic             pass_go;
  bpa_pkg::count_t  pass_lo;
  bpa_pkg::count_t  pass_hi;
  bpa_pkg::count_t  pass_end_pg;

  logic             ram_we;
  logic [AW-1:0]    ram_wa;
  bpa_pkg::word_t   ram_wd;
  bpa_pkg::word_t   rdata;

  bpa_pkg::count_t  last_pg;
  logic [BW-1:0]    lo_bit;
  logic [BW-1:0]    hi_bit;
  bpa_pkg::word_t   mask;
  logic             pass_last;
  logic [BW:0]      cnt_new;
  logic [BW:0]      cnt_free;
  bpa_pkg::find_t   fres;
  bpa_pkg::count_t  found_start;
  logic [CW:0]      sum_end;
  bpa_pkg::count_t  free_end;
  bpa_pkg::count_t  cfg_total;
  logic             accept;

  bpa_ram #(.WIDTH(WB), .DEPTH(bpa_pkg::MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  assign last_pg   = rng_hi - CW'(1);
  assign lo_bit    = (p_addr == rng_lo[PW-1:BW]) ? rng_lo[BW-1:0] : '0;
  assign hi_bit    = (p_addr == last_pg[PW-1:BW]) ? last_pg[BW-1:0] : '1;
  assign mask      = ({WB{1'b1}} << lo_bit) & ({WB{1'b1}} >> (BW'(WB - 1) - hi_bit));
  assign pass_last = p_valid && (p_addr == rd_last);
  assign cnt_new   = popcnt(mask & ~rdata);
  assign cnt_free  = popcnt(mask & rdata);

  bpa_word_find u_find (
    .avail  (rdata & mask),
    .lo     (lo_bit),
    .run_in (run),
    .need   (req_n),
    .res    (fres)
  );

  assign found_start = {1'b0, p_addr, fres.pos} + CW'(1) - req_n;
  assign sum_end     = {2'b00, req.first_page} + {1'b0, req.page_count};
  assign free_end    = (sum_end > {1'b0, total}) ? total : sum_end[CW-1:0];
  assign cfg_total   = (cfg_wdata > CW'(bpa_pkg::MAX_PAGES)) ? CW'(bpa_pkg::MAX_PAGES)
                                                              : cfg_wdata;
  assign req.ready   = (state == ST_IDLE) && !cfg_we;
  assign accept      = req.valid && req.ready;
  assign pass_end_pg = pass_hi - CW'(1);

  always_comb begin
    state_next      = state;
    total_next      = total;
    free_count_next = free_count;
    hint_next       = hint;
    req_kind_next   = req_kind;
    req_first_next  = req_first;
    req_n_next      = req_n;
    rng_lo_next     = rng_lo;
    rng_hi_next     = rng_hi;
    rd_last_next    = rd_last;
    acc_next        = acc;
    run_next        = run;
    wrap_pend_next  = wrap_pend;
    res_status_next = res_status;
    res_start_next  = res_start;
    out_load        = 1'b0;
    pass_go         = 1'b0;
    pass_lo         = rng_lo;
    pass_hi         = rng_hi;
    ram_we          = 1'b0;
    ram_wa          = p_addr;
    ram_wd          = rdata;

    // advance the read walker
    p_valid_next = rd_run;
    p_addr_next  = rd_addr;
    rd_run_next  = rd_run && (rd_addr != rd_last);
    rd_addr_next = rd_run ? rd_addr + AW'(1) : rd_addr;

    case (state)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_wa       = rd_addr;
        ram_wd       = '0;
        rd_addr_next = rd_addr + AW'(1);
        if (rd_addr == AW'(bpa_pkg::MAP_WORDS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          req_kind_next  = req.kind;
          req_first_next = req.first_page;
          req_n_next     = req.page_count;
          res_start_next = '0;
          res_status_next = 1'b1;
          state_next     = ST_RESP;
          case (req.kind)
            bpa_pkg::KIND_ALLOC: begin
              if (req.page_count != '0 && req.page_count <= total) begin
                pass_go    = 1'b1;
                pass_hi    = total;
                state_next = ST_SCAN;
                if ({1'b0, hint} < total) begin
                  pass_lo        = {1'b0, hint};
                  wrap_pend_next = 1'b1;
                end else begin
                  pass_lo        = '0;
                  wrap_pend_next = 1'b0;
                end
              end
            end
            bpa_pkg::KIND_FREE: begin
              hint_next       = req.first_page;
              res_status_next = 1'b0;
              if ({1'b0, req.first_page} < free_end) begin
                pass_go    = 1'b1;
                pass_lo    = {1'b0, req.first_page};
                pass_hi    = free_end;
                state_next = ST_FREE;
              end
            end
            bpa_pkg::KIND_CLAIM: begin
              if (req.page_count != '0 && sum_end <= {1'b0, total}) begin
                pass_go    = 1'b1;
                pass_lo    = {1'b0, req.first_page};
                pass_hi    = sum_end[CW-1:0];
                state_next = ST_CHECK;
              end
            end
            default: begin
              res_status_next = 1'b1;
            end
          endcase
        end
      end
      ST_RECOUNT: begin
        if (p_valid) begin
          acc_next = acc + CW'(cnt_free);
          if (pass_last) begin
            free_count_next = acc_next;
            state_next      = ST_IDLE;
          end
        end
      end
      ST_FREE: begin
        if (p_valid) begin
          ram_we          = 1'b1;
          ram_wd          = rdata | mask;
          free_count_next = free_count + CW'(cnt_new);
          if (pass_last) begin
            state_next = ST_RESP;
          end
        end
      end
      ST_CHECK: begin
        if (p_valid) begin
          if ((mask & ~rdata) != '0) begin
            res_status_next = 1'b1;
            state_next      = ST_RESP;
          end else if (pass_last) begin
            res_start_next = req_first;
            pass_go        = 1'b1;
            pass_lo        = rng_lo;
            pass_hi        = rng_hi;
            state_next     = ST_TAKE;
          end
        end
      end
      ST_TAKE: begin
        if (p_valid) begin
          ram_we = 1'b1;
          ram_wd = rdata & ~mask;
          if (pass_last) begin
            free_count_next = free_count - req_n;
            res_status_next = 1'b0;
            if (req_kind == bpa_pkg::KIND_ALLOC) begin
              hint_next = res_start;
            end
            state_next = ST_RESP;
          end
        end
      end
      ST_SCAN: begin
        if (p_valid) begin
          if (fres.found) begin
            res_start_next = found_start[PW-1:0];
            pass_go        = 1'b1;
            pass_lo        = found_start;
            pass_hi        = found_start + req_n;
            state_next     = ST_TAKE;
          end else begin
            run_next = fres.run_out;
            if (pass_last) begin
              if (wrap_pend) begin
                wrap_pend_next = 1'b0;
                pass_go        = 1'b1;
                pass_lo        = '0;
                pass_hi        = total;
              end else begin
                res_status_next = 1'b1;
                state_next      = ST_RESP;
              end
            end
          end
        end
      end
      ST_RESP: begin
        if (!rsp.valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // take a new total and recount the free pages below it
    if (cfg_we) begin
      total_next = cfg_total;
      if (state != ST_CLEAR) begin
        acc_next = '0;
        if (cfg_total == '0) begin
          free_count_next = '0;
          rd_run_next     = 1'b0;
          p_valid_next    = 1'b0;
          state_next      = ST_IDLE;
        end else begin
          pass_go    = 1'b1;
          pass_lo    = '0;
          pass_hi    = cfg_total;
          state_next = ST_RECOUNT;
        end
      end
    end

    if (pass_go) begin
      rng_lo_next  = pass_lo;
      rng_hi_next  = pass_hi;
      rd_addr_next = pass_lo[PW-1:BW];
      rd_last_next = pass_end_pg[PW-1:BW];
      rd_run_next  = 1'b1;
      p_valid_next = 1'b0;
      run_next     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      total      <= CW'(bpa_pkg::MAX_PAGES);
      free_count <= '0;
      hint       <= '0;
      rd_addr    <= '0;
      rd_run     <= 1'b0;
      p_valid    <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state      <= state_next;
      total      <= total_next;
      free_count <= free_count_next;
      hint       <= hint_next;
      rd_addr    <= rd_addr_next;
      rd_run     <= rd_run_next;
      p_valid    <= p_valid_next;
      if (out_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_kind   <= req_kind_next;
    req_first  <= req_first_next;
    req_n      <= req_n_next;
    rng_lo     <= rng_lo_next;
    rng_hi     <= rng_hi_next;
    rd_last    <= rd_last_next;
    p_addr     <= p_addr_next;
    acc        <= acc_next;
    run        <= run_next;
    wrap_pend  <= wrap_pend_next;
    res_status <= res_status_next;
    res_start  <= res_start_next;
    if (out_load) begin
      rsp.status     <= res_status;
      rsp.start_page <= res_start;
      rsp.used_count <= (total > free_count) ? total - free_count : '0;
    end
  end

  `BPA_ASSERT_IMPL(a_ready_idle, req.ready, state == ST_IDLE, "request taken while busy")
  `BPA_ASSERT_IMPL(a_free_le_total, state == ST_IDLE, free_count <= total,
                   "free count above total")
  `BPA_ASSERT_IMPL(a_wb_valid, ram_we && state != ST_CLEAR, p_valid,
                   "write back without read data")
  `BPA_ASSERT_NEXT(a_resp_hold, state == ST_RESP && rsp.valid && !rsp.ready && !cfg_we,
                   state == ST_RESP, "result dropped while output stalled")

endmodule

// ===== tb/bpa_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bitmap page allocator checker
// Watches the request, response and configuration ports, keeps its own copy
// of the free-page map, hint and free count, predicts each response and
// compares it field by field with what the allocator returns.
// ---------------------------------------------------------------------------
module bpa_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  bpa_pkg::count_t cfg_wdata,
  bpa_req_if              req,
  bpa_rsp_if              rsp,
  output int              errors,
  output int              pending,
  output int              responses
);
  import bpa_pkg::*;

  typedef struct packed {
    logic   status;
    page_t  start_page;
    count_t used_count;
  } alloc_rsp_t;

  bit          page_free [MAX_PAGES];
  int unsigned hint_page;
  int unsigned free_pages;
  int unsigned page_limit;
  alloc_rsp_t  expected_rsps[$];

  function automatic bit find_free_run(int unsigned from, int unsigned lim, int unsigned n,
                                       output int unsigned start);
    int unsigned run;
    run = 0;
    start = 0;
    for (int unsigned p = from; p < lim; p++) begin
      run = page_free[p] ? run + 1 : 0;
      if (run == n) begin
        start = p + 1 - n;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void set_total(int unsigned v);
    page_limit = (v > MAX_PAGES) ? MAX_PAGES : v;
    free_pages = 0;
    for (int unsigned p = 0; p < page_limit; p++)
      if (page_free[p]) free_pages++;
  endfunction

  function automatic alloc_rsp_t predict_alloc(kind_t kind, int unsigned first, int unsigned n);
    alloc_rsp_t  r;
    bit          ok;
    int unsigned start, stop;
    r.status = 1'b1;
    start = 0;
    case (kind)
      KIND_ALLOC: begin
        if (n != 0 && n <= page_limit) begin
          ok = 1'b0;
          if (hint_page < page_limit) ok = find_free_run(hint_page, page_limit, n, start);
          if (!ok) ok = find_free_run(0, page_limit, n, start);
          if (ok) begin
            for (int unsigned p = start; p < start + n; p++) page_free[p] = 1'b0;
            free_pages -= n;
            hint_page = start & 16'hFFFF;
            r.status = 1'b0;
          end else begin
            start = 0;
          end
        end
      end
      KIND_FREE: begin
        stop = first + n;
        if (stop > page_limit) stop = page_limit;
        for (int unsigned p = first; p < stop; p++) begin
          if (!page_free[p]) begin
            page_free[p] = 1'b1;
            free_pages++;
          end
        end
        hint_page = first;
        r.status = 1'b0;
      end
      KIND_CLAIM: begin
        if (n != 0 && first + n <= page_limit) begin
          ok = 1'b1;
          for (int unsigned p = first; p < first + n; p++)
            if (!page_free[p]) ok = 1'b0;
          if (ok) begin
            for (int unsigned p = first; p < first + n; p++) page_free[p] = 1'b0;
            free_pages -= n;
            start = first;
            r.status = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.start_page = start[PAGE_W-1:0];
    r.used_count = (page_limit > free_pages) ? count_t'(page_limit - free_pages) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    alloc_rsp_t e;
    if (rst) begin
      for (int p = 0; p < MAX_PAGES; p++) page_free[p] = 1'b0;
      hint_page = 0;
      free_pages = 0;
      page_limit = MAX_PAGES;
      expected_rsps.delete();
      errors <= 0;
      responses <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) set_total(cfg_wdata);
      if (req.valid && req.ready)
        expected_rsps.push_back(predict_alloc(req.kind, req.first_page, req.page_count));
      if (rsp.valid && rsp.ready) begin
        responses <= responses + 1;
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected transfer status=%0b start=%0d used=%0d", $time,
                   rsp.status, rsp.start_page, rsp.used_count);
          errors <= errors + 1;
        end else begin
          e = expected_rsps.pop_front();
          if (rsp.status !== e.status || rsp.start_page !== e.start_page ||
              rsp.used_count !== e.used_count) begin
            $display("%0t: mismatch expected status=%0b start=%0d used=%0d, actual %0b %0d %0d",
                     $time, e.status, e.start_page, e.used_count,
                     rsp.status, rsp.start_page, rsp.used_count);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_rsps.size();
    end
  end
endmodule

// ===== tb/bitmap_page_allocator_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Bitmap page allocator testbench
// Drives directed and random allocate, free and claim requests over several
// page totals with random gaps and response stalls; the checker predicts
// and compares every response.
// ---------------------------------------------------------------------------
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam kind_t KIND_BAD = 2'd3;

  logic   clk;
  logic   rst;
  logic   cfg_we;
  count_t cfg_wdata;
  int     errors, pending, responses;
  int     sent;
  int     cur_total;
  bit     done;

  bpa_req_if req ();
  bpa_rsp_if rsp ();

  bitmap_page_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  bpa_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .responses (responses)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_req(kind_t kind, int unsigned first, int unsigned n);
    int gap;
    gap = pick_gap();
    if (gap > 0 && req.valid) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.kind       <= kind;
    req.first_page <= first[PAGE_W-1:0];
    req.page_count <= n[CNT_W-1:0];
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_total(int unsigned v);
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[CNT_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_total = (v > MAX_PAGES) ? MAX_PAGES : v;
  endtask

  task automatic random_req();
    int          r;
    kind_t       kind;
    int unsigned first, n, hi;
    hi = (cur_total > 0) ? cur_total - 1 : 0;
    r = $urandom_range(0, 99);
    if (r < 40) kind = KIND_ALLOC;
    else if (r < 75) kind = KIND_FREE;
    else if (r < 95) kind = KIND_CLAIM;
    else kind = KIND_BAD;
    first = ($urandom_range(0, 9) != 0) ? $urandom_range(0, hi) : $urandom_range(0, 65535);
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(1, 8);
    else if (r < 90) n = $urandom_range(1, 64);
    else if (r < 97) n = $urandom_range(1, (cur_total > 0) ? cur_total : 1);
    else n = $urandom_range(0, 131071);
    send_req(kind, first, n);
  endtask

  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 99) < 3) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(20, 50)) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        rsp.ready <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else begin
        rsp.ready <= ($urandom_range(0, 99) < 70);
      end
    end
  end

  initial begin
    int unsigned totals[8];
    totals         = '{300, 131071, 1, 0, 2000, 64, 65535, 33};
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req.valid      = 1'b0;
    req.kind       = KIND_ALLOC;
    req.first_page = '0;
    req.page_count = '0;
    sent           = 0;
    cur_total      = MAX_PAGES;
    done           = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_req(KIND_ALLOC, 0, 1);
    send_req(KIND_CLAIM, 0, 1);
    send_req(KIND_ALLOC, 0, 0);
    send_req(KIND_FREE, 77, 0);
    send_req(KIND_FREE, 65535, 131071);
    send_req(KIND_FREE, 0, 65536);
    send_req(KIND_ALLOC, 0, 65536);
    send_req(KIND_ALLOC, 0, 1);
    send_req(KIND_FREE, 100, 200);
    send_req(KIND_CLAIM, 150, 10);
    send_req(KIND_CLAIM, 150, 10);
    send_req(KIND_CLAIM, 160, 0);
    send_req(KIND_ALLOC, 0, 40);
    send_req(KIND_ALLOC, 0, 131071);
    send_req(KIND_BAD, 65535, 131071);
    send_req(KIND_CLAIM, 65500, 100);
    send_req(KIND_FREE, 65535, 1);
    send_req(KIND_CLAIM, 65535, 1);
    send_req(KIND_ALLOC, 0, 300);
    repeat (40) random_req();

    foreach (totals[i]) begin
      write_total(totals[i]);
      if (cur_total > 0)
        send_req(KIND_FREE, $urandom_range(0, cur_total - 1), $urandom_range(1, cur_total));
      repeat (55) random_req();
    end

    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests over %0d page totals, %0d responses checked.",
             sent, 9, responses);
    done = 1'b1;
    if (errors == 0) begin
      $display("bitmap_page_allocator_tb passed");
    end else begin
      $display("bitmap_page_allocator_tb failed");
    end
    $finish;
  end

  initial begin
    #500ms;
    if (!done) begin
      $display("bitmap_page_allocator_tb failed");
      $finish;
    end
  end
endmodule
